// ===== rtl/bbr_pkg.sv =====
package bbr_pkg;

  localparam logic [22:0] HALF_CLOCKS_PER_SECOND = 23'd7000000;
  localparam logic [15:0] RATE_MIN = 16'd8000;
  localparam logic [15:0] RATE_MAX = 16'd48000;
  localparam logic [6:0]  LAST_SLOT = 7'd63;

  localparam logic [2:0] OP_ADVANCE = 3'd0;
  localparam logic [2:0] OP_PORT    = 3'd1;
  localparam logic [2:0] OP_EAR     = 3'd2;
  localparam logic [2:0] OP_ENABLE  = 3'd3;
  localparam logic [2:0] OP_SOFT    = 3'd4;

  localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] REG_SPEAKER     = 3'd1;
  localparam logic [2:0] REG_MIC         = 3'd2;
  localparam logic [2:0] REG_EAR         = 3'd3;
  localparam logic [2:0] REG_FULL        = 3'd4;
  localparam logic [2:0] REG_POLE        = 3'd5;
  localparam logic [2:0] REG_PEAK        = 3'd6;

  localparam logic [7:0] PORT_SPEAKER_BIT = 8'h10;
  localparam logic [7:0] PORT_MIC_BIT     = 8'h08;

  typedef struct packed {
    logic load;
    logic tick;
    logic den;
    logic sat_chk;
    logic div;
    logic pmul;
    logic ycalc;
    logic smul;
    logic scale;
    logic push_new;
    logic flush;
    logic apply;
  } bbr_cmd_t;

  typedef struct packed {
    logic adv;
    logic wrap;
    logic span_one;
    logic span_zero;
    logic div_sat;
    logic div_last;
    logic pend_valid;
    logic out_free;
    logic cnt_last;
  } bbr_stat_t;

endpackage

// ===== rtl/beeper_box_resampler_dc_block_core.sv =====
// sequence: an event beat is loaded, a decide state picks ticking or a direct apply, then the tick
// state steps through the elapsed half-clocks; each phase wrap runs den, saturation check, the
// bit-serial divider (skipped when the quotient saturates), pole multiply, ycalc, scale multiply,
// scale and push; one event at a time, and push and flush wait while the output is stalled
// each sample is held one sample back so tlast can be set on the last sample of an event
// reset: rst is synchronous active high; configuration registers return to defaults, state clears
module beeper_box_resampler_dc_block_core import bbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // elapsed_ticks[12:0], port_value[20:13], flag[21], zero pad
  input  logic [2:0]  s_tuser,   // operation[2:0]
  // sample stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample[15:0]
  output logic        m_tlast
);

  bbr_cmd_t  cmd;
  bbr_stat_t st;
  logic signed [15:0] sample;

  // sequencer: tick loop, divider steps, filter and output beats
  bbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // accumulators, divider, dc blocker and output register
  bbr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (s_tuser),
    .in_elapsed_ticks (s_tdata[12:0]),
    .in_port_value    (s_tdata[20:13]),
    .in_flag          (s_tdata[21]),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_sample       (sample),
    .out_last         (m_tlast)
  );

  assign m_tdata = sample;

endmodule

// ===== rtl/bbr_ctrl.sv =====
module bbr_ctrl import bbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bbr_stat_t st,
  output bbr_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_DEN   = 4'd3;
  localparam logic [3:0] S_SAT   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PMUL  = 4'd6;
  localparam logic [3:0] S_YCALC = 4'd7;
  localparam logic [3:0] S_SMUL  = 4'd8;
  localparam logic [3:0] S_SCALE = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;
  localparam logic [3:0] S_APPLY = 4'd12;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = st.adv ? S_TICK : S_APPLY;
      S_TICK: begin
        cmd.tick = 1'b1;
        if (st.wrap) state_next = S_DEN;
        else if (st.span_one) state_next = S_FLUSH;
      end
      S_DEN: begin
        cmd.den = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat_chk = 1'b1;
        state_next = st.div_sat ? S_PMUL : S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.pmul = 1'b1;
        state_next = S_YCALC;
      end
      S_YCALC: begin
        cmd.ycalc = 1'b1;
        state_next = S_SMUL;
      end
      S_SMUL: begin
        cmd.smul = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!st.pend_valid || st.out_free) begin
          cmd.push_new = 1'b1;
          state_next = (st.cnt_last || st.span_zero) ? S_FLUSH : S_TICK;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_APPLY;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bbr_datapath.sv =====
module bbr_datapath import bbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         in_operation,
  input  logic [12:0]        in_elapsed_ticks,
  input  logic [7:0]         in_port_value,
  input  logic               in_flag,
  input  bbr_cmd_t           cmd,
  output bbr_stat_t          st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_last
);

  logic [15:0] out_rate;
  logic [7:0]  spk_gain, mic_gain, ear_gain;
  logic [9:0]  full_scale;
  logic [15:0] dc_pole;
  logic [14:0] peak_gain;

  logic [8:0]  port_level;
  logic [7:0]  ear_contrib;
  logic        is_enabled;
  logic [19:0] level_sum;
  logic [9:0]  tick_count;
  logic [22:0] phase_acc;
  logic [16:0] prev_input;
  logic signed [19:0] prev_output;

  logic [2:0]  op;
  logic [12:0] span;
  logic [7:0]  port;
  logic        flag;

  logic [19:0] den;
  logic [36:0] rem;
  logic [16:0] x;
  logic [4:0]  div_i;
  logic signed [36:0] prod;
  logic signed [19:0] y;
  logic signed [35:0] sprod;
  logic signed [15:0] news;
  logic signed [15:0] pend;
  logic        pend_valid;
  logic [6:0]  cnt;

  logic [15:0] rate_clamped;
  logic [23:0] psum;
  logic [9:0]  full_eff;
  logic [36:0] trial;
  logic signed [21:0] ywide;
  logic signed [36:0] adj;
  logic signed [20:0] scaled;
  logic        out_free;
  logic [9:0]  lvl;

  assign lvl = {1'b0, port_level} + {2'b0, ear_contrib};
  assign psum = {1'b0, phase_acc} + {8'b0, out_rate};
  assign full_eff = (full_scale == 10'd0) ? 10'd1 : full_scale;
  assign trial = {17'b0, den} << div_i;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    rate_clamped = cfg_data;
    if (cfg_data < RATE_MIN) rate_clamped = RATE_MIN;
    if (cfg_data > RATE_MAX) rate_clamped = RATE_MAX;
  end

  always_comb begin
    ywide = $signed({5'b0, x}) - $signed({5'b0, prev_input}) + 22'($signed(prod[36:16]));
    adj = (sprod < 0) ? (37'(sprod) + 37'sd65535) : 37'(sprod);
    scaled = adj[36:16];
  end

  always_comb begin
    st.adv = !((op == OP_ENABLE && flag != is_enabled) || op == OP_SOFT)
             && is_enabled && (span != 13'd0);
    st.wrap = (psum >= {1'b0, HALF_CLOCKS_PER_SECOND});
    st.span_one = (span == 13'd1);
    st.span_zero = (span == 13'd0);
    st.div_sat = (rem >= {den, 17'b0}) || (den == 20'd0);
    st.div_last = (div_i == 5'd0);
    st.pend_valid = pend_valid;
    st.out_free = out_free;
    st.cnt_last = (cnt == LAST_SLOT);
  end

  // configuration and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_rate <= 16'd44100;
      spk_gain <= 8'd128;
      mic_gain <= 8'd16;
      ear_gain <= 8'd32;
      full_scale <= 10'd176;
      dc_pole <= 16'd65208;
      peak_gain <= 15'd24576;
      port_level <= '0;
      ear_contrib <= '0;
      is_enabled <= 1'b0;
      level_sum <= '0;
      tick_count <= '0;
      phase_acc <= '0;
      prev_input <= '0;
      prev_output <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE: begin
            if (cfg_data != 16'd0 && rate_clamped != out_rate) begin
              out_rate <= rate_clamped;
              level_sum <= '0;
              tick_count <= '0;
              phase_acc <= '0;
            end
          end
          REG_SPEAKER: spk_gain <= cfg_data[7:0];
          REG_MIC: mic_gain <= cfg_data[7:0];
          REG_EAR: ear_gain <= cfg_data[7:0];
          REG_FULL: full_scale <= cfg_data[9:0];
          REG_POLE: dc_pole <= cfg_data;
          REG_PEAK: peak_gain <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        level_sum <= level_sum + {10'b0, lvl};
        tick_count <= tick_count + 10'd1;
        phase_acc <= st.wrap ? 23'(psum - {1'b0, HALF_CLOCKS_PER_SECOND}) : psum[22:0];
      end
      if (cmd.den) begin
        level_sum <= '0;
        tick_count <= '0;
      end
      if (cmd.ycalc) begin
        prev_input <= x;
        if (ywide > 22'sd524287) prev_output <= 20'sd524287;
        else if (ywide < -22'sd524288) prev_output <= -20'sd524288;
        else prev_output <= ywide[19:0];
      end
      if (cmd.apply) begin
        unique case (op)
          OP_PORT: begin
            port_level <= ((port & PORT_SPEAKER_BIT) != 8'd0 ? {1'b0, spk_gain} : 9'd0)
                        + ((port & PORT_MIC_BIT) != 8'd0 ? {1'b0, mic_gain} : 9'd0);
          end
          OP_EAR: ear_contrib <= flag ? ear_gain : 8'd0;
          OP_ENABLE: begin
            if (flag != is_enabled) begin
              is_enabled <= flag;
              if (flag) begin
                level_sum <= '0;
                tick_count <= '0;
                phase_acc <= '0;
                prev_input <= '0;
                prev_output <= '0;
              end
            end
          end
          OP_SOFT: begin
            ear_contrib <= '0;
            level_sum <= '0;
            tick_count <= '0;
            phase_acc <= '0;
            prev_input <= '0;
            prev_output <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // item latch and sample arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_operation;
      span <= in_elapsed_ticks;
      port <= in_port_value;
      flag <= in_flag;
    end
    if (cmd.tick) span <= span - 13'd1;
    if (cmd.den) begin
      den <= {10'b0, tick_count} * {10'b0, full_eff};
      rem <= {1'b0, level_sum, 16'b0};
    end
    if (cmd.sat_chk) begin
      x <= st.div_sat ? ((den == 20'd0) ? 17'd0 : 17'h1FFFF) : 17'd0;
      div_i <= 5'd16;
    end
    if (cmd.div) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        x[div_i] <= 1'b1;
      end
      div_i <= div_i - 5'd1;
    end
    if (cmd.pmul) prod <= $signed({1'b0, dc_pole}) * prev_output;
    if (cmd.ycalc) begin
      if (ywide > 22'sd524287) y <= 20'sd524287;
      else if (ywide < -22'sd524288) y <= -20'sd524288;
      else y <= ywide[19:0];
    end
    if (cmd.smul) sprod <= y * $signed({1'b0, peak_gain});
    if (cmd.scale) begin
      if (scaled > 21'sd32767) news <= 16'sh7FFF;
      else if (scaled < -21'sd32768) news <= -16'sd32768;
      else news <= scaled[15:0];
    end
    if (cmd.push_new) pend <= news;
  end

  // pending sample and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.flush || (cmd.push_new && pend_valid)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.push_new) begin
        pend_valid <= 1'b1;
        cnt <= cnt + 7'd1;
        if (pend_valid) begin
          out_sample <= pend;
          out_last <= 1'b0;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_sample <= pend;
        out_last <= 1'b1;
      end
      if (cmd.apply) begin
        pend_valid <= 1'b0;
        cnt <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush || (cmd.push_new && pend_valid)) |-> out_free)
    else $error("output register overwritten");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_acc < HALF_CLOCKS_PER_SECOND)
    else $error("phase accumulator out of range");
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count <= 10'd875)
    else $error("box tick count overflow");
`endif

endmodule
